// ===== rtl/assert_macros.svh =====
// Assertion macros used by the controller back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define FDC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define FDC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fdc_pkg.sv =====
// Types and constants of the floppy disk controller.
`timescale 1ns / 1ps
package fdc_pkg;

    localparam int SECTOR_BYTES = 256;
    localparam int LOAD_AW      = 18;

    localparam logic [7:0] ST_BUSY      = 8'h01;
    localparam logic [7:0] ST_DRQ       = 8'h02;
    localparam logic [7:0] ST_TRACK0    = 8'h04;
    localparam logic [7:0] ST_RNF       = 8'h10;
    localparam logic [7:0] ST_PROTECT   = 8'h40;
    localparam logic [7:0] ST_NOT_READY = 8'h80;
    localparam logic [7:0] CTRL_RD_MASK = 8'h1C;
    localparam logic [9:0] DELAY_XFER   = 10'd32;
    localparam logic [9:0] DELAY_TYPE1  = 10'd512;

    localparam logic [3:0] CMD_RESTORE  = 4'h0;
    localparam logic [3:0] CMD_SEEK     = 4'h1;
    localparam logic [3:0] CMD_STEP_IN  = 4'h4;
    localparam logic [3:0] CMD_STEP_INU = 4'h5;
    localparam logic [3:0] CMD_STEP_OUT = 4'h6;
    localparam logic [3:0] CMD_STEP_OTU = 4'h7;
    localparam logic [3:0] CMD_READ     = 4'h8;
    localparam logic [3:0] CMD_READ_M   = 4'h9;
    localparam logic [3:0] CMD_WRITE    = 4'hA;
    localparam logic [3:0] CMD_WRITE_M  = 4'hB;
    localparam logic [3:0] CMD_READ_ADR = 4'hC;
    localparam logic [3:0] CMD_FORCE    = 4'hD;
    localparam logic [3:0] CMD_RD_TRK   = 4'hE;
    localparam logic [3:0] CMD_WR_TRK   = 4'hF;

    localparam logic [2:0] CFG_ENABLED  = 3'd0;
    localparam logic [2:0] CFG_MOUNTED  = 3'd1;
    localparam logic [2:0] CFG_PROTECT  = 3'd2;
    localparam logic [2:0] CFG_TEN_SECT = 3'd3;
    localparam logic [2:0] CFG_TRACKS   = 3'd4;

    localparam logic [1:0] FN_READ  = 2'd0;
    localparam logic [1:0] FN_WRITE = 2'd1;
    localparam logic [1:0] FN_TICK  = 2'd2;
    localparam logic [1:0] FN_LOAD  = 2'd3;

    localparam logic [2:0] RG_STATUS  = 3'd0;
    localparam logic [2:0] RG_TRACK   = 3'd1;
    localparam logic [2:0] RG_SECTOR  = 3'd2;
    localparam logic [2:0] RG_DATA    = 3'd3;
    localparam logic [2:0] RG_CONTROL = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  reg_offset;
        logic [7:0]  wdata;
        logic [31:0] elapsed_cycles;
        logic [2:0]  load_unit;
        logic [17:0] load_address;
    } in_word_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       irq_assert;
        logic       intrq_level;
    } out_word_t;

    typedef enum logic [3:0] {
        OP_NOP, OP_RSTAT, OP_RTRK, OP_RSEC, OP_RDATA, OP_RCTL,
        OP_CMD, OP_WTRK, OP_WSEC, OP_WDATA, OP_WCTL, OP_TICK, OP_LOAD
    } item_op_t;

    typedef struct packed {
        item_op_t    op;
        logic [7:0]  wdata;
        logic [31:0] elapsed_cycles;
        logic [2:0]  load_unit;
        logic [17:0] load_address;
    } q_word_t;

    typedef enum logic [1:0] {XF_NONE, XF_READ, XF_WRITE, XF_ADDR} xfer_kind_t;

    typedef enum logic [2:0] {CS_IDLE, CS_EXEC, CS_RCOPY, CS_WCOPY, CS_IDW} core_state_t;

endpackage

// ===== rtl/floppy_disk_controller_unit.sv =====
// Floppy disk controller top level: front decoder/queue and execution back end.
`timescale 1ns / 1ps
// An item passes through two back-end states (dequeue, execute), and the front
// queue takes a new word every cycle while it has room. A read sector command
// holds the back end while the sector is copied from the disk store into the sector
// buffer; the last data write of a write sector holds it for the commit; read
// address holds it to build the ID field. These copies run one byte a cycle
// through the buffer and disk store, which each have a read and a write port. The
// result of each item is posted before any copy starts. There is no clearing pass:
// the disk store holds whatever image bytes were loaded.
module floppy_disk_controller_unit #(
    parameter int UNITS       = 8,
    parameter int MAX_TRACKS  = 80,
    parameter int MAX_SECTORS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fdc_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output fdc_pkg::out_word_t out_word,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [55:0]        cfg_data
);
    logic             enabled;
    logic             q_valid, q_ready;
    fdc_pkg::q_word_t q_word;

    assign cfg_ready = 1'b1;

    fdc_front #(
        .UNITS(UNITS), .MAX_TRACKS(MAX_TRACKS), .MAX_SECTORS(MAX_SECTORS)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .enabled(enabled),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
    );

    fdc_core #(
        .UNITS(UNITS), .MAX_TRACKS(MAX_TRACKS), .MAX_SECTORS(MAX_SECTORS)
    ) u_core (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .enabled(enabled),
        .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
    );
endmodule

// ===== rtl/fdc_front.sv =====
// Front end: accepts words, decodes them into operations, two-entry queue.
`timescale 1ns / 1ps
module fdc_front #(
    parameter int UNITS       = 8,
    parameter int MAX_TRACKS  = 80,
    parameter int MAX_SECTORS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               enabled,
    input  logic               in_valid,
    output logic               in_ready,
    input  fdc_pkg::in_word_t  in_word,
    output logic               q_valid,
    input  logic               q_ready,
    output fdc_pkg::q_word_t   q_word
);
    localparam int UNIT_BYTES = MAX_TRACKS * MAX_SECTORS * fdc_pkg::SECTOR_BYTES;

    fdc_pkg::q_word_t fifo_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    fdc_pkg::item_op_t op;
    logic push, pop;

    always_comb
    begin
        op = fdc_pkg::OP_NOP;
        case (in_word.func)
            fdc_pkg::FN_READ:
                if (enabled)
                begin
                    case (in_word.reg_offset)
                        fdc_pkg::RG_STATUS:  op = fdc_pkg::OP_RSTAT;
                        fdc_pkg::RG_TRACK:   op = fdc_pkg::OP_RTRK;
                        fdc_pkg::RG_SECTOR:  op = fdc_pkg::OP_RSEC;
                        fdc_pkg::RG_DATA:    op = fdc_pkg::OP_RDATA;
                        fdc_pkg::RG_CONTROL: op = fdc_pkg::OP_RCTL;
                        default:             op = fdc_pkg::OP_NOP;
                    endcase
                end
            fdc_pkg::FN_WRITE:
                if (enabled)
                begin
                    case (in_word.reg_offset)
                        fdc_pkg::RG_STATUS:  op = fdc_pkg::OP_CMD;
                        fdc_pkg::RG_TRACK:   op = fdc_pkg::OP_WTRK;
                        fdc_pkg::RG_SECTOR:  op = fdc_pkg::OP_WSEC;
                        fdc_pkg::RG_DATA:    op = fdc_pkg::OP_WDATA;
                        fdc_pkg::RG_CONTROL: op = fdc_pkg::OP_WCTL;
                        default:             op = fdc_pkg::OP_NOP;
                    endcase
                end
            fdc_pkg::FN_TICK: op = fdc_pkg::OP_TICK;
            default:
                if ({1'b0, in_word.load_unit} < 4'(UNITS)
                    && {1'b0, in_word.load_address} < 19'(UNIT_BYTES))
                    op = fdc_pkg::OP_LOAD;
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_word   = fifo_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg].op             <= op;
            fifo_reg[wr_ptr_reg].wdata          <= in_word.wdata;
            fifo_reg[wr_ptr_reg].elapsed_cycles <= in_word.elapsed_cycles;
            fifo_reg[wr_ptr_reg].load_unit      <= in_word.load_unit;
            fifo_reg[wr_ptr_reg].load_address   <= in_word.load_address;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

// ===== rtl/fdc_core.sv =====
// Back end: register file, command execution, sector buffer and disk store.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fdc_core #(
    parameter int UNITS       = 8,
    parameter int MAX_TRACKS  = 80,
    parameter int MAX_SECTORS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [2:0]         cfg_index,
    input  logic [55:0]        cfg_data,
    output logic               enabled,
    input  logic               q_valid,
    output logic               q_ready,
    input  fdc_pkg::q_word_t   q_word,
    output logic               out_valid,
    input  logic               out_ready,
    output fdc_pkg::out_word_t out_word
);
    localparam int DEPTH = UNITS * (1 << fdc_pkg::LOAD_AW);
    localparam int AW    = $clog2(DEPTH);

    // configuration
    logic        enabled_reg;
    logic [7:0]  mounted_reg, protect_reg, ten_reg;
    logic [55:0] tracks_reg;

    // controller state
    fdc_pkg::core_state_t state_reg, state_next;
    fdc_pkg::xfer_kind_t  xk_reg, xk_next;
    logic [7:0] status_reg, status_next, track_reg, track_next, sector_reg, sector_next;
    logic [7:0] data_reg, data_next, ctl_reg, ctl_next;
    logic       intrq_reg, intrq_next, drq_reg, drq_next, hl_reg, hl_next;
    logic [8:0] xpos_reg, xpos_next, xlen_reg, xlen_next, cnt_reg, cnt_next;
    logic [9:0] cc_reg, cc_next;
    logic [AW-1:0] base_reg, base_next;
    fdc_pkg::q_word_t   cur_reg;
    logic               out_valid_reg;
    fdc_pkg::out_word_t out_reg, out_d;
    logic               out_load;

    // memories
    logic [7:0] buf_mem [fdc_pkg::SECTOR_BYTES];
    logic [7:0] disk_mem [DEPTH];
    logic [7:0] buf_q, disk_q, buf_wd, disk_wd;
    logic [7:0] buf_ra, buf_wa;
    logic       buf_we, disk_we;
    logic [AW-1:0] disk_ra, disk_wa;

    // sector lookup on the selected unit
    logic [2:0]  unit;
    logic        unit_rdy, found;
    logic [6:0]  tcount;
    logic [3:0]  spt;
    logic [11:0] sidx;
    logic [AW-1:0] found_addr;
    logic [3:0]  top;
    logic [7:0]  rd;
    logic        irq, do_end;

    always_comb
    begin
        unit     = {ctl_reg[3:2], ctl_reg[4]};
        unit_rdy = ({1'b0, unit} < 4'(UNITS)) && mounted_reg[unit];
        tcount   = tracks_reg[unit*7 +: 7];
        if (tcount > 7'(MAX_TRACKS))
            tcount = 7'(MAX_TRACKS);
        spt   = (ten_reg[unit] && MAX_SECTORS >= 10) ? 4'd10 : 4'd9;
        found = unit_rdy && ({1'b0, track_reg} < {2'b0, tcount}) && (sector_reg != 8'd0)
                && (sector_reg <= {4'd0, spt});
        sidx       = 12'(track_reg * spt) + {4'd0, sector_reg} - 12'd1;
        found_addr = AW'({unit, sidx[9:0], 8'd0});
    end

    always_comb
    begin
        state_next  = state_reg;
        xk_next     = xk_reg;
        status_next = status_reg;
        track_next  = track_reg;
        sector_next = sector_reg;
        data_next   = data_reg;
        ctl_next    = ctl_reg;
        intrq_next  = intrq_reg;
        drq_next    = drq_reg;
        hl_next     = hl_reg;
        xpos_next   = xpos_reg;
        xlen_next   = xlen_reg;
        cnt_next    = cnt_reg;
        cc_next     = cc_reg;
        base_next   = base_reg;
        q_ready     = 1'b0;
        out_load    = 1'b0;
        buf_we      = 1'b0;
        buf_wa      = xpos_reg[7:0];
        buf_wd      = cur_reg.wdata;
        buf_ra      = xpos_reg[7:0];
        disk_we     = 1'b0;
        disk_wa     = AW'({cur_reg.load_unit, cur_reg.load_address});
        disk_wd     = cur_reg.wdata;
        disk_ra     = AW'(base_reg | AW'(cnt_reg[7:0]));
        rd          = 8'd0;
        irq         = 1'b0;
        do_end      = 1'b0;
        top         = cur_reg.wdata[7:4];
        case (state_reg)
            fdc_pkg::CS_IDLE:
                if (q_valid && (!out_valid_reg || out_ready))
                begin
                    q_ready    = 1'b1;
                    state_next = fdc_pkg::CS_EXEC;
                end
            fdc_pkg::CS_EXEC:
            begin
                state_next = fdc_pkg::CS_IDLE;
                case (cur_reg.op)
                    fdc_pkg::OP_RSTAT:
                    begin
                        intrq_next = 1'b0;
                        rd         = status_reg;
                    end
                    fdc_pkg::OP_RTRK: rd = track_reg;
                    fdc_pkg::OP_RSEC: rd = sector_reg;
                    fdc_pkg::OP_RCTL:
                        rd = (ctl_reg & fdc_pkg::CTRL_RD_MASK) | {drq_reg, hl_reg, 5'd0, intrq_reg};
                    fdc_pkg::OP_RDATA:
                        if (xk_reg == fdc_pkg::XF_READ || xk_reg == fdc_pkg::XF_ADDR)
                        begin
                            data_next = buf_q;
                            rd        = buf_q;
                            xpos_next = xpos_reg + 9'd1;
                            do_end    = (xpos_next >= xlen_reg);
                        end
                        else
                            rd = data_reg;
                    fdc_pkg::OP_WTRK: track_next  = cur_reg.wdata;
                    fdc_pkg::OP_WSEC: sector_next = cur_reg.wdata;
                    fdc_pkg::OP_WCTL:
                    begin
                        ctl_next = cur_reg.wdata;
                        irq      = intrq_reg && cur_reg.wdata[0];
                    end
                    fdc_pkg::OP_WDATA:
                    begin
                        data_next = cur_reg.wdata;
                        if (xk_reg == fdc_pkg::XF_WRITE)
                        begin
                            buf_we    = 1'b1;
                            xpos_next = xpos_reg + 9'd1;
                            if (xpos_next >= xlen_reg)
                            begin
                                do_end = 1'b1;
                                if (!found)
                                    status_next = fdc_pkg::ST_RNF;
                                else
                                begin
                                    // commit runs after the result is posted
                                    state_next = fdc_pkg::CS_WCOPY;
                                    base_next  = found_addr;
                                    cnt_next   = 9'd0;
                                end
                            end
                        end
                    end
                    fdc_pkg::OP_CMD:
                    begin
                        intrq_next = 1'b0;
                        cc_next    = 10'd0;
                        if (top inside {fdc_pkg::CMD_READ, fdc_pkg::CMD_READ_M, fdc_pkg::CMD_WRITE,
                                        fdc_pkg::CMD_WRITE_M, fdc_pkg::CMD_READ_ADR})
                        begin
                            hl_next = 1'b1;
                            if (!unit_rdy)
                            begin
                                status_next = fdc_pkg::ST_NOT_READY | fdc_pkg::ST_RNF;
                                do_end      = 1'b1;
                            end
                            else if (top == fdc_pkg::CMD_READ_ADR)
                            begin
                                status_next = fdc_pkg::ST_BUSY | fdc_pkg::ST_DRQ;
                                xk_next     = fdc_pkg::XF_ADDR;
                                xpos_next   = 9'd0;
                                xlen_next   = 9'd6;
                                drq_next    = 1'b1;
                                state_next  = fdc_pkg::CS_IDW;
                                cnt_next    = 9'd0;
                            end
                            else if (top inside {fdc_pkg::CMD_WRITE, fdc_pkg::CMD_WRITE_M}
                                     && protect_reg[unit])
                            begin
                                status_next = fdc_pkg::ST_PROTECT;
                                do_end      = 1'b1;
                            end
                            else if (!found)
                            begin
                                status_next = fdc_pkg::ST_RNF;
                                do_end      = 1'b1;
                            end
                            else
                            begin
                                status_next = fdc_pkg::ST_BUSY | fdc_pkg::ST_DRQ;
                                xpos_next   = 9'd0;
                                xlen_next   = 9'(fdc_pkg::SECTOR_BYTES);
                                drq_next    = 1'b1;
                                if (top inside {fdc_pkg::CMD_READ, fdc_pkg::CMD_READ_M})
                                begin
                                    xk_next    = fdc_pkg::XF_READ;
                                    state_next = fdc_pkg::CS_RCOPY;
                                    base_next  = found_addr;
                                    cnt_next   = 9'd0;
                                end
                                else
                                    xk_next = fdc_pkg::XF_WRITE;
                            end
                        end
                        else if (top == fdc_pkg::CMD_FORCE)
                        begin
                            status_next = 8'd0;
                            drq_next    = 1'b0;
                            xk_next     = fdc_pkg::XF_NONE;
                            intrq_next  = (cur_reg.wdata[3:0] != 4'd0);
                            irq         = intrq_next && ctl_reg[0];
                        end
                        else if (top inside {fdc_pkg::CMD_RD_TRK, fdc_pkg::CMD_WR_TRK})
                        begin
                            status_next = fdc_pkg::ST_RNF;
                            do_end      = 1'b1;
                        end
                        else
                        begin
                            // type I
                            xk_next  = fdc_pkg::XF_NONE;
                            drq_next = 1'b0;
                            hl_next  = cur_reg.wdata[3];
                            if (top == fdc_pkg::CMD_RESTORE)
                                track_next = 8'd0;
                            else if (top == fdc_pkg::CMD_SEEK)
                                track_next = data_reg;
                            else if (top inside {fdc_pkg::CMD_STEP_IN, fdc_pkg::CMD_STEP_INU})
                            begin
                                if (track_reg != 8'hFF)
                                    track_next = track_reg + 8'd1;
                            end
                            else if (top inside {fdc_pkg::CMD_STEP_OUT, fdc_pkg::CMD_STEP_OTU})
                            begin
                                if (track_reg != 8'd0)
                                    track_next = track_reg - 8'd1;
                            end
                            status_next = 8'd0;
                            if (track_next == 8'd0)
                                status_next = status_next | fdc_pkg::ST_TRACK0;
                            if (!unit_rdy)
                                status_next = status_next | fdc_pkg::ST_NOT_READY;
                            cc_next = fdc_pkg::DELAY_TYPE1;
                        end
                    end
                    fdc_pkg::OP_TICK:
                        if (cc_reg != 10'd0)
                        begin
                            if ({22'd0, cc_reg} <= cur_reg.elapsed_cycles)
                            begin
                                cc_next    = 10'd0;
                                intrq_next = 1'b1;
                                irq        = ctl_reg[0];
                            end
                            else
                                cc_next = cc_reg - 10'(cur_reg.elapsed_cycles);
                        end
                    fdc_pkg::OP_LOAD: disk_we = 1'b1;
                    default: rd = 8'd0;
                endcase
                if (do_end)
                begin
                    status_next = status_next & ~(fdc_pkg::ST_BUSY | fdc_pkg::ST_DRQ);
                    drq_next    = 1'b0;
                    xk_next     = fdc_pkg::XF_NONE;
                    xpos_next   = 9'd0;
                    xlen_next   = 9'd0;
                    cc_next     = fdc_pkg::DELAY_XFER;
                end
                out_load = 1'b1;
            end
            fdc_pkg::CS_RCOPY:
            begin
                // disk read is registered, so the buffer write trails it by one byte address
                buf_we   = (cnt_reg != 9'd0);
                buf_wa   = 8'(cnt_reg - 9'd1);
                buf_wd   = disk_q;
                cnt_next = cnt_reg + 9'd1;
                if (cnt_reg == 9'(fdc_pkg::SECTOR_BYTES))
                    state_next = fdc_pkg::CS_IDLE;
            end
            fdc_pkg::CS_WCOPY:
            begin
                buf_ra   = cnt_reg[7:0];
                disk_we  = (cnt_reg != 9'd0);
                disk_wa  = AW'(base_reg | AW'(8'(cnt_reg - 9'd1)));
                disk_wd  = buf_q;
                cnt_next = cnt_reg + 9'd1;
                if (cnt_reg == 9'(fdc_pkg::SECTOR_BYTES))
                    state_next = fdc_pkg::CS_IDLE;
            end
            fdc_pkg::CS_IDW:
            begin
                // ID field: track, side, sector, size code 1, two CRC bytes
                buf_we = 1'b1;
                buf_wa = cnt_reg[7:0];
                case (cnt_reg[2:0])
                    3'd0:    buf_wd = track_reg;
                    3'd1:    buf_wd = {7'd0, unit[0]};
                    3'd2:    buf_wd = (sector_reg != 8'd0) ? sector_reg : 8'd1;
                    3'd3:    buf_wd = 8'd1;
                    default: buf_wd = 8'd0;
                endcase
                cnt_next = cnt_reg + 9'd1;
                if (cnt_reg == 9'd5)
                    state_next = fdc_pkg::CS_IDLE;
            end
            default: state_next = fdc_pkg::CS_IDLE;
        endcase
        out_d.rdata       = rd;
        out_d.irq_assert  = irq;
        out_d.intrq_level = intrq_next;
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
            buf_mem[buf_wa] <= buf_wd;
        buf_q <= buf_mem[buf_ra];
    end

    always_ff @(posedge clk)
    begin
        if (disk_we)
            disk_mem[disk_wa] <= disk_wd;
        disk_q <= disk_mem[disk_ra];
    end

    always_ff @(posedge clk)
    begin
        if (q_ready)
            cur_reg <= q_word;
        if (out_load)
            out_reg <= out_d;
        base_reg <= base_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b0;
            mounted_reg   <= 8'd0;
            protect_reg   <= 8'd0;
            ten_reg       <= 8'hFF;
            tracks_reg    <= 56'd22606304011898960;
            state_reg     <= fdc_pkg::CS_IDLE;
            xk_reg        <= fdc_pkg::XF_NONE;
            status_reg    <= fdc_pkg::ST_TRACK0;
            track_reg     <= 8'd0;
            sector_reg    <= 8'd1;
            data_reg      <= 8'd0;
            ctl_reg       <= 8'h20;
            intrq_reg     <= 1'b0;
            drq_reg       <= 1'b0;
            hl_reg        <= 1'b0;
            xpos_reg      <= 9'd0;
            xlen_reg      <= 9'd0;
            cnt_reg       <= 9'd0;
            cc_reg        <= 10'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    fdc_pkg::CFG_ENABLED:  enabled_reg <= cfg_data[0];
                    fdc_pkg::CFG_MOUNTED:  mounted_reg <= cfg_data[7:0];
                    fdc_pkg::CFG_PROTECT:  protect_reg <= cfg_data[7:0];
                    fdc_pkg::CFG_TEN_SECT: ten_reg     <= cfg_data[7:0];
                    fdc_pkg::CFG_TRACKS:   tracks_reg  <= cfg_data;
                    default:               ;
                endcase
            end
            state_reg  <= state_next;
            xk_reg     <= xk_next;
            status_reg <= status_next;
            track_reg  <= track_next;
            sector_reg <= sector_next;
            data_reg   <= data_next;
            ctl_reg    <= ctl_next;
            intrq_reg  <= intrq_next;
            drq_reg    <= drq_next;
            hl_reg     <= hl_next;
            xpos_reg   <= xpos_next;
            xlen_reg   <= xlen_next;
            cnt_reg    <= cnt_next;
            cc_reg     <= cc_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign enabled   = enabled_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    `FDC_ASSERT_ALWAYS(a_drq_kind, drq_reg == (xk_reg != fdc_pkg::XF_NONE), "drq/transfer mismatch")
    `FDC_ASSERT_ALWAYS(a_pos_len, xpos_reg <= xlen_reg, "transfer position past length")
    `FDC_ASSERT_IMPL(a_rcopy_kind, state_reg == fdc_pkg::CS_RCOPY, xk_reg == fdc_pkg::XF_READ, "sector fill outside read")
    `FDC_ASSERT_IMPL(a_exec_slot, state_reg == fdc_pkg::CS_EXEC, !out_valid_reg, "result slot busy at execute")
endmodule
